@@ design/dcmar_pkg.sv @@
package dcmar_pkg;

   localparam int TIME_BITS_DEFAULT = 24;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      MAIN_ENABLED    = 2'd0,
      MAIN_STOP       = 2'd1,
      MAIN_OPEN       = 2'd2,
      MAIN_STOP_AFTER = 2'd3
   } main_mode_type;

   typedef enum logic [1:0] {
      SUB_PASS  = 2'd0,
      SUB_BLANK = 2'd1,
      SUB_ALARM = 2'd2
   } sub_mode_type;

   localparam logic [2:0] REG_SAMPLE_TIME         = 3'd0;
   localparam logic [2:0] REG_CHANGE_DELAY        = 3'd1;
   localparam logic [2:0] REG_REVERSE_DELAY       = 3'd2;
   localparam logic [2:0] REG_AFTER_REVERSE_DELAY = 3'd3;
   localparam logic [2:0] REG_DELTA_POS           = 3'd4;

   localparam int OUT_SCL = 0;
   localparam int OUT_SOP = 1;
   localparam int OUT_CL  = 2;
   localparam int OUT_OP  = 3;
   localparam int OUT_AR  = 4;
   localparam int OUT_SPD = 5;

   // slow close at reduced speed
   localparam logic [5:0] HELD_ALARM = 6'b100101;
   localparam logic [5:0] HELD_SPD   = 6'b100000;

   typedef struct packed {
      logic [15:0] sample_time;
      logic [23:0] change_delay;
      logic [23:0] reverse_delay;
      logic [23:0] after_reverse_delay;
      logic [15:0] delta_pos;
   } cfg_type;

   typedef struct packed {
      logic [15:0] position;
      logic        close_limit;
      logic        open_limit;
      logic        auto_mode;
      logic        reversal_request;
      logic        alarm_close;
      logic        reverse_cmd;
      logic        open_cmd;
      logic        close_cmd;
      logic        slow_open_cmd;
      logic        slow_close_cmd;
   } req_type;

   typedef struct packed {
      main_mode_type main_mode;
      sub_mode_type  sub_mode;
      logic          prev_request;
      logic [5:0]    held;
   } ctl_type;

endpackage

@@ design/door_command_mask_auto_reverse.sv @@
// Door drive command mask with auto-reverse.
// req_ channel: one request per control tick, carrying the five requested
//   drive commands, alarm close, reversal trigger, auto mode, both limit
//   switches and the door position.
// rsp_ channel: one response per request with the five masked commands and
//   the speed divide bit.
// csr_ port: APB-style access to sample_time, change_delay, reverse_delay,
//   after_reverse_delay and delta_pos at byte addresses 0, 4, 8, 12, 16.
// The response is registered: a request accepted at an edge has its response
//   valid in the following cycle. Throughput is one request per cycle while
//   rsp_tready holds, set by the next-state logic feeding the response register.
// req_tready stays high while the response register is empty or being
//   drained, so a stalled receiver holds one response and back-pressures.
// Reset clears the mode machines, timer, saved position, reversal edge
//   detector and held commands, and loads the register defaults.
module door_command_mask_auto_reverse import dcmar_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slow_close_cmd, slow_open_cmd, close_cmd, open_cmd, reverse_cmd,
   // alarm_close, reversal_request, auto_mode, open_limit, close_limit,
   // position[15:0], zero pad
   input  logic [31:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slow_close_out, slow_open_out, close_out, open_out, reverse_out,
   // speed_divide, zero pad
   output logic [7:0]            rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type              cfg_ff;
   ctl_type              ctl_ff;
   ctl_type              ctl_in;
   logic [TIME_BITS-1:0] elapsed_ff;
   logic [TIME_BITS-1:0] elapsed_in;
   logic [15:0]          saved_ff;
   logic [15:0]          saved_in;
   logic                 rsp_tvalid_ff;
   logic [7:0]           rsp_tdata_ff;
   logic                 req_accept;
   logic                 csr_write;
   logic [2:0]           csr_index;
   req_type              req;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_time         <= 16'd1;
         cfg_ff.change_delay        <= 24'd1000;
         cfg_ff.reverse_delay       <= 24'd1000;
         cfg_ff.after_reverse_delay <= 24'd1000;
         cfg_ff.delta_pos           <= 16'd100;
      end else if (csr_write) begin
         case (csr_index)
            REG_SAMPLE_TIME:         cfg_ff.sample_time         <= csr_pwdata[15:0];
            REG_CHANGE_DELAY:        cfg_ff.change_delay        <= csr_pwdata[23:0];
            REG_REVERSE_DELAY:       cfg_ff.reverse_delay       <= csr_pwdata[23:0];
            REG_AFTER_REVERSE_DELAY: cfg_ff.after_reverse_delay <= csr_pwdata[23:0];
            REG_DELTA_POS:           cfg_ff.delta_pos           <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SAMPLE_TIME:         csr_prdata = 32'(cfg_ff.sample_time);
         REG_CHANGE_DELAY:        csr_prdata = 32'(cfg_ff.change_delay);
         REG_REVERSE_DELAY:       csr_prdata = 32'(cfg_ff.reverse_delay);
         REG_AFTER_REVERSE_DELAY: csr_prdata = 32'(cfg_ff.after_reverse_delay);
         REG_DELTA_POS:           csr_prdata = 32'(cfg_ff.delta_pos);
         default:                 csr_prdata = '0;
      endcase
   end

   assign req        = req_tdata[$bits(req_type)-1:0];
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   dcmar_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg        (cfg_ff),
      .req        (req),
      .ctl_ff     (ctl_ff),
      .elapsed_ff (elapsed_ff),
      .saved_ff   (saved_ff),
      .ctl_in     (ctl_in),
      .elapsed_in (elapsed_in),
      .saved_in   (saved_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.main_mode    <= MAIN_ENABLED;
         ctl_ff.sub_mode     <= SUB_PASS;
         ctl_ff.prev_request <= 1'b0;
         ctl_ff.held         <= '0;
         elapsed_ff          <= '0;
         saved_ff            <= '0;
         rsp_tvalid_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            ctl_ff        <= ctl_in;
            elapsed_ff    <= elapsed_in;
            saved_ff      <= saved_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= {2'b00, ctl_in.held};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ design/dcmar_step.sv @@
module dcmar_step import dcmar_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  cfg_type              cfg,
   input  req_type              req,
   input  ctl_type              ctl_ff,
   input  logic [TIME_BITS-1:0] elapsed_ff,
   input  logic [15:0]          saved_ff,
   output ctl_type              ctl_in,
   output logic [TIME_BITS-1:0] elapsed_in,
   output logic [15:0]          saved_in
);

   localparam int SUM_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
   localparam int CMP_W = (TIME_BITS > 24) ? TIME_BITS : 24;

   logic [SUM_W-1:0]     tick_sum;
   logic [TIME_BITS-1:0] tick_val;
   logic                 ge_change;
   logic                 ge_reverse;
   logic                 ge_after;
   logic                 travel_done;

   assign tick_sum = SUM_W'(elapsed_ff) + SUM_W'(cfg.sample_time);
   assign tick_val = (tick_sum > {{(SUM_W-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}}) ?
                     {TIME_BITS{1'b1}} : tick_sum[TIME_BITS-1:0];

   assign ge_change  = CMP_W'(tick_val) >= CMP_W'(cfg.change_delay);
   assign ge_reverse = CMP_W'(tick_val) >= CMP_W'(cfg.reverse_delay);
   assign ge_after   = CMP_W'(tick_val) >= CMP_W'(cfg.after_reverse_delay);
   assign travel_done = 17'(req.position) >= (17'(saved_ff) + 17'(cfg.delta_pos));

   always_comb begin
      logic hold_tick;
      hold_tick  = 1'b0;
      ctl_in     = ctl_ff;
      elapsed_in = elapsed_ff;
      saved_in   = saved_ff;
      case (ctl_ff.main_mode)
         MAIN_ENABLED: begin
            case (ctl_ff.sub_mode)
               SUB_PASS: begin
                  if (ctl_ff.held[OUT_OP] && !(req.slow_open_cmd || req.open_cmd)) begin
                     // open just ended: blank, nothing else this tick
                     ctl_in.sub_mode = SUB_BLANK;
                     hold_tick       = 1'b1;
                  end else begin
                     ctl_in.held = {1'b0, req.reverse_cmd, req.open_cmd, req.close_cmd,
                                    req.slow_open_cmd, req.slow_close_cmd};
                     if (req.alarm_close) begin
                        elapsed_in = tick_val;
                        if (ge_change) begin
                           elapsed_in      = '0;
                           ctl_in.sub_mode = SUB_ALARM;
                        end
                     end
                  end
               end
               SUB_BLANK: begin
                  ctl_in.held = ctl_ff.held & HELD_SPD;
                  elapsed_in  = tick_val;
                  if (ge_change) begin
                     elapsed_in      = '0;
                     ctl_in.sub_mode = SUB_PASS;
                  end
               end
               SUB_ALARM: begin
                  if (req.alarm_close) begin
                     ctl_in.held = HELD_ALARM;
                  end else begin
                     elapsed_in = tick_val;
                     if (ge_change) begin
                        elapsed_in      = '0;
                        ctl_in.sub_mode = SUB_PASS;
                     end
                  end
               end
               default: begin
               end
            endcase
            if (!hold_tick) begin
               if (req.reversal_request && !ctl_ff.prev_request) begin
                  ctl_in.main_mode = MAIN_STOP;
                  saved_in         = req.position;
                  elapsed_in       = '0;
               end
               ctl_in.prev_request = req.reversal_request;
            end
         end
         MAIN_STOP: begin
            ctl_in.held = '0;
            elapsed_in  = tick_val;
            if (ge_reverse) begin
               ctl_in.main_mode = MAIN_OPEN;
               elapsed_in       = '0;
            end
         end
         MAIN_OPEN: begin
            elapsed_in = tick_val;
            ctl_in.held[OUT_AR]  = 1'b0;
            ctl_in.held[OUT_SCL] = 1'b0;
            ctl_in.held[OUT_CL]  = 1'b0;
            ctl_in.held[OUT_OP]  = 1'b1;
            ctl_in.held[OUT_SOP] = 1'b1;
            if (!req.auto_mode) begin
               if (ge_reverse || travel_done) begin
                  ctl_in.held[OUT_OP]  = 1'b0;
                  ctl_in.held[OUT_SOP] = 1'b0;
                  ctl_in.main_mode     = MAIN_STOP_AFTER;
                  saved_in             = '0;
                  elapsed_in           = '0;
               end
            end else if (req.open_limit || req.close_limit) begin
               ctl_in.main_mode = MAIN_STOP_AFTER;
            end
         end
         default: begin
            elapsed_in  = tick_val;
            ctl_in.held = ctl_ff.held & HELD_SPD;
            if (ge_after) begin
               ctl_in.main_mode = MAIN_ENABLED;
               elapsed_in       = '0;
            end
         end
      endcase
   end

endmodule

@@ design/dcmar_checker.sv @@
module dcmar_checker import dcmar_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // response register comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request without response");

   // reduced speed only with the forced slow close pattern
   a_speed_divide_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[OUT_SPD] |-> rsp_tdata[5:0] == HELD_ALARM)
      else $error("speed divide outside alarm slow close");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind door_command_mask_auto_reverse dcmar_checker u_checker (.*);

@@ verif/tb.sv @@
module tb import dcmar_pkg::*; ();

   localparam int TB_TIME_BITS = TIME_BITS_DEFAULT;

   // addresses past the last register; writes there must be dropped
   localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
   localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

   localparam logic [4:0] CMD_NONE      = 5'b00000;
   localparam logic [4:0] CMD_SLOW_OPEN = 5'b00010;
   localparam logic [4:0] CMD_CLOSE     = 5'b00100;
   localparam logic [4:0] CMD_OPEN      = 5'b01000;
   localparam logic [4:0] CMD_ALL       = 5'b11111;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   bit      steady_send;
   req_type gen_state;

   class door_mask_checker;
      cfg_type                 cfg;
      main_mode_type           main_mode;
      sub_mode_type            sub_mode;
      logic [TB_TIME_BITS-1:0] elapsed;
      logic [15:0]             saved_pos;
      logic                    prev_reversal;
      logic [5:0]              held;
      logic [5:0]              expected_cmds[$];
      string                   field_names[6];
      int                      mismatches;

      function new();
         cfg.sample_time = 16'd1;
         cfg.change_delay = 24'd1000;
         cfg.reverse_delay = 24'd1000;
         cfg.after_reverse_delay = 24'd1000;
         cfg.delta_pos = 16'd100;
         main_mode = MAIN_ENABLED;
         sub_mode = SUB_PASS;
         elapsed = '0;
         saved_pos = '0;
         prev_reversal = 1'b0;
         held = '0;
         mismatches = 0;
         field_names = '{"slow_close_out", "slow_open_out", "close_out", "open_out",
                         "reverse_out", "speed_divide"};
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
      endfunction

      function void set_config(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_SAMPLE_TIME:         cfg.sample_time = v[15:0];
            REG_CHANGE_DELAY:        cfg.change_delay = v[23:0];
            REG_REVERSE_DELAY:       cfg.reverse_delay = v[23:0];
            REG_AFTER_REVERSE_DELAY: cfg.after_reverse_delay = v[23:0];
            REG_DELTA_POS:           cfg.delta_pos = v[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] idx);
         case (idx)
            REG_SAMPLE_TIME:         return {16'd0, cfg.sample_time};
            REG_CHANGE_DELAY:        return {8'd0, cfg.change_delay};
            REG_REVERSE_DELAY:       return {8'd0, cfg.reverse_delay};
            REG_AFTER_REVERSE_DELAY: return {8'd0, cfg.after_reverse_delay};
            REG_DELTA_POS:           return {16'd0, cfg.delta_pos};
            default:                 return '0;
         endcase
      endfunction

      // saturating timer
      function void advance_timer();
         logic [TB_TIME_BITS:0] sum;
         sum = {1'b0, elapsed} + (TB_TIME_BITS+1)'(cfg.sample_time);
         if (sum[TB_TIME_BITS])
            elapsed = '1;
         else
            elapsed = sum[TB_TIME_BITS-1:0];
      endfunction

      function void predict_tick(req_type r);
         logic open_fell;
         open_fell = 1'b0;
         case (main_mode)
            MAIN_ENABLED: begin
               case (sub_mode)
                  SUB_PASS: begin
                     if (held[OUT_OP] && !(r.slow_open_cmd || r.open_cmd)) begin
                        sub_mode = SUB_BLANK;
                        open_fell = 1'b1;
                     end else begin
                        held = '0;
                        held[OUT_SCL] = r.slow_close_cmd;
                        held[OUT_SOP] = r.slow_open_cmd;
                        held[OUT_CL] = r.close_cmd;
                        held[OUT_OP] = r.open_cmd;
                        held[OUT_AR] = r.reverse_cmd;
                        if (r.alarm_close) begin
                           advance_timer();
                           if (elapsed >= cfg.change_delay) begin
                              elapsed = '0;
                              sub_mode = SUB_ALARM;
                           end
                        end
                     end
                  end
                  SUB_BLANK: begin
                     held &= HELD_SPD;
                     advance_timer();
                     if (elapsed >= cfg.change_delay) begin
                        elapsed = '0;
                        sub_mode = SUB_PASS;
                     end
                  end
                  SUB_ALARM: begin
                     if (r.alarm_close) begin
                        held = HELD_ALARM;
                     end else begin
                        advance_timer();
                        if (elapsed >= cfg.change_delay) begin
                           elapsed = '0;
                           sub_mode = SUB_PASS;
                        end
                     end
                  end
                  default: ;
               endcase
               // the tick that catches the open falling edge skips edge detection
               if (!open_fell) begin
                  if (r.reversal_request && !prev_reversal) begin
                     main_mode = MAIN_STOP;
                     saved_pos = r.position;
                     elapsed = '0;
                  end
                  prev_reversal = r.reversal_request;
               end
            end
            MAIN_STOP: begin
               held = '0;
               advance_timer();
               if (elapsed >= cfg.reverse_delay) begin
                  main_mode = MAIN_OPEN;
                  elapsed = '0;
               end
            end
            MAIN_OPEN: begin
               advance_timer();
               held[OUT_AR] = 1'b0;
               held[OUT_SCL] = 1'b0;
               held[OUT_CL] = 1'b0;
               held[OUT_OP] = 1'b1;
               held[OUT_SOP] = 1'b1;
               if (!r.auto_mode) begin
                  if (elapsed >= cfg.reverse_delay ||
                      {1'b0, r.position} >= {1'b0, saved_pos} + {1'b0, cfg.delta_pos}) begin
                     held[OUT_OP] = 1'b0;
                     held[OUT_SOP] = 1'b0;
                     main_mode = MAIN_STOP_AFTER;
                     saved_pos = '0;
                     elapsed = '0;
                  end
               end else if (r.open_limit || r.close_limit) begin
                  main_mode = MAIN_STOP_AFTER;
               end
            end
            default: begin
               advance_timer();
               held &= HELD_SPD;
               if (elapsed >= cfg.after_reverse_delay) begin
                  main_mode = MAIN_ENABLED;
                  elapsed = '0;
               end
            end
         endcase
         expected_cmds.push_back(held);
      endfunction

      function void check_masked(logic [7:0] d);
         logic [5:0] want;
         if (expected_cmds.size() == 0) begin
            flag("response with no request outstanding", '0, 32'(d));
            return;
         end
         want = expected_cmds.pop_front();
         for (int j = 0; j < 6; j++)
            if (d[j] !== want[j])
               flag(field_names[j], 32'(want[j]), 32'(d[j]));
      endfunction
   endclass

   door_mask_checker mask_check;

   door_command_mask_auto_reverse dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return $urandom_range(1, 2);
      if (roll < 92)
         return $urandom_range(3, 6);
      return $urandom_range(15, 50);
   endfunction

   function automatic req_type tick_item(logic [4:0] cmds, logic alarm, logic rev,
                                         logic auto_m, logic olim, logic clim,
                                         logic [15:0] pos);
      return {pos, clim, olim, auto_m, rev, alarm, cmds};
   endfunction

   // mostly slow-moving controls with a drifting position, some pure noise
   function automatic req_type next_item(req_type p);
      req_type     r;
      logic [25:0] noise;
      logic [4:0]  cmds;
      int          pos;
      int          roll;
      noise = 26'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         r = noise;
         return r;
      end
      r = p;
      cmds = {r.reverse_cmd, r.open_cmd, r.close_cmd, r.slow_open_cmd, r.slow_close_cmd};
      for (int j = 0; j < 5; j++)
         if ($urandom_range(0, 99) < 30)
            cmds[j] = ~cmds[j];
      {r.reverse_cmd, r.open_cmd, r.close_cmd, r.slow_open_cmd, r.slow_close_cmd} = cmds;
      if ($urandom_range(0, 99) < 8)
         r.alarm_close = ~r.alarm_close;
      if ($urandom_range(0, 99) < 5)
         r.reversal_request = ~r.reversal_request;
      if ($urandom_range(0, 99) < 3)
         r.auto_mode = ~r.auto_mode;
      r.open_limit = ($urandom_range(0, 9) == 0);
      r.close_limit = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         r.position = 16'($urandom);
      end else if (roll < 12) begin
         r.position = roll[0] ? 16'hFFFF : 16'h0000;
      end else begin
         pos = int'(p.position) + int'($urandom_range(0, 40)) - 10;
         r.position = (pos < 0) ? 16'h0000 : (pos > 65535) ? 16'hFFFF : 16'(pos);
      end
      return r;
   endfunction

   task automatic send_request(req_type r);
      req_tdata = {6'd0, r};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      mask_check.predict_tick(r);
      @(negedge clock);
      if (!steady_send && $urandom_range(0, 1) == 0) begin
         req_tvalid = 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      @(negedge clock);
      while (mask_check.expected_cmds.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic [2:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = write;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      if (write)
         mask_check.set_config(idx, wdata);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic verify_registers();
      logic [31:0] got;
      for (int i = REG_SAMPLE_TIME; i <= REG_DELTA_POS; i++) begin
         csr_access(1'b0, 3'(i), '0, got);
         if (got !== mask_check.reg_value(3'(i)))
            mask_check.flag("register readback", mask_check.reg_value(3'(i)), got);
      end
   endtask

   task automatic apply_settings(logic [15:0] st, logic [23:0] cd, logic [23:0] rd,
                                 logic [23:0] ard, logic [15:0] dp);
      logic [31:0] vals[5];
      logic [31:0] keep;
      logic [31:0] unused;
      vals[REG_SAMPLE_TIME] = {16'd0, st};
      vals[REG_CHANGE_DELAY] = {8'd0, cd};
      vals[REG_REVERSE_DELAY] = {8'd0, rd};
      vals[REG_AFTER_REVERSE_DELAY] = {8'd0, ard};
      vals[REG_DELTA_POS] = {16'd0, dp};
      wait_drained();
      for (int i = REG_SAMPLE_TIME; i <= REG_DELTA_POS; i++) begin
         keep = (i == REG_SAMPLE_TIME || i == REG_DELTA_POS) ? 32'h0000_FFFF : 32'h00FF_FFFF;
         csr_access(1'b1, 3'(i), vals[i] | ($urandom & ~keep), unused);
      end
      verify_registers();
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0)
            steady_send = ($urandom_range(0, 3) == 0);
         if (i == n / 2 || $urandom_range(0, 199) == 0)
            wait_drained();
         gen_state = next_item(gen_state);
         send_request(gen_state);
      end
   endtask

   initial begin
      int stall;
      int span;
      bit steady_recv;
      rsp_tready = 1'b0;
      stall = 0;
      span = 0;
      steady_recv = 1'b0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            steady_recv = ($urandom_range(0, 3) == 0);
            span = $urandom_range(50, 300);
         end
         span--;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            if (!steady_recv && $urandom_range(0, 2) == 0)
               stall = pick_gap();
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         mask_check.check_masked(rsp_tdata);

   initial begin
      logic [31:0] scratch;
      mask_check = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      steady_send = 1'b0;
      gen_state = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      verify_registers();
      run_random(80);

      apply_settings(16'd1, 24'd2, 24'd2, 24'd2, 16'd5);
      send_request(tick_item(CMD_NONE, 0, 0, 0, 0, 0, 16'h0000));
      send_request(tick_item(CMD_ALL, 0, 0, 0, 1, 1, 16'hFFFF));
      send_request(tick_item(CMD_OPEN, 0, 0, 0, 0, 0, 16'h1234));
      send_request(tick_item(CMD_OPEN | CMD_SLOW_OPEN, 0, 0, 0, 0, 0, 16'h1234));
      // open drops with a reversal edge on the same tick: edge is ignored
      send_request(tick_item(CMD_NONE, 0, 1, 0, 0, 0, 16'h1234));
      send_request(tick_item(CMD_NONE, 0, 0, 0, 0, 0, 16'h1234));
      send_request(tick_item(CMD_NONE, 0, 0, 0, 0, 0, 16'h1234));
      repeat (4) send_request(tick_item(CMD_CLOSE, 1, 0, 0, 0, 0, 16'h0100));
      repeat (2) send_request(tick_item(CMD_OPEN, 0, 0, 0, 0, 0, 16'h0100));
      // travel target must not wrap past 16 bits
      send_request(tick_item(CMD_OPEN, 0, 1, 0, 0, 0, 16'hFFFF));
      repeat (2) send_request(tick_item(CMD_NONE, 0, 1, 0, 0, 0, 16'hFFFF));
      repeat (2) send_request(tick_item(CMD_ALL, 0, 1, 0, 0, 0, 16'hFFFF));
      repeat (2) send_request(tick_item(CMD_NONE, 0, 1, 0, 0, 0, 16'hFFFF));
      send_request(tick_item(CMD_NONE, 0, 0, 0, 0, 0, 16'h0064));
      send_request(tick_item(CMD_CLOSE, 0, 1, 1, 0, 0, 16'h0064));
      repeat (2) send_request(tick_item(CMD_NONE, 0, 1, 1, 0, 0, 16'h0064));
      send_request(tick_item(CMD_NONE, 0, 1, 1, 0, 0, 16'h0070));
      send_request(tick_item(CMD_NONE, 0, 1, 1, 1, 0, 16'h0080));
      repeat (2) send_request(tick_item(CMD_NONE, 0, 1, 1, 0, 1, 16'h0080));
      run_random(300);

      apply_settings(16'd2, 24'd0, 24'd0, 24'd0, 16'd0);
      run_random(200);

      apply_settings(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
      run_random(300);

      apply_settings(16'($urandom_range(1, 8)), 24'($urandom_range(0, 20)),
                     24'($urandom_range(0, 20)), 24'($urandom_range(0, 20)),
                     16'($urandom_range(0, 200)));
      run_random(250);

      apply_settings(16'd7, 24'd12, 24'd9, 24'd15, 16'd30);
      csr_access(1'b1, REG_UNMAPPED_LO, $urandom, scratch);
      csr_access(1'b1, REG_UNMAPPED_HI, $urandom, scratch);
      verify_registers();
      run_random(270);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mask_check.mismatches == 0 && mask_check.expected_cmds.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
design/dcmar_pkg.sv
design/dcmar_step.sv
design/door_command_mask_auto_reverse.sv
design/dcmar_checker.sv
verif/tb.sv
